>>> src/segment_resize_to_length_top_macros.svh
// assertion helpers for the segment resize block
`ifndef SEGMENT_RESIZE_TO_LENGTH_TOP_MACROS_SVH
`define SEGMENT_RESIZE_TO_LENGTH_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRL_ASSERT_NOW(label, ante, cons, msg)
`define SRL_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> src/srl_pkg.sv
`default_nettype none
package srl_pkg;

  localparam int CW = 32;   // coordinate width
  localparam int LW = 31;   // length width
  localparam int QW = 31;   // offset bits, one cell each
  localparam int SW = 65;   // a^2 + b^2
  localparam int TW = 126;  // (len * a)^2 and remainder
  localparam int YW = 97;   // running q * S
  localparam int IW = 129;  // trial increment

  // per-word values that ride along the pipe
  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic [LW-1:0]        len;
    logic                 vert;
    logic                 horiz;
    logic                 xpos;
    logic                 ypos;
  } side_t;

  // state of one axis in the bit recurrence
  typedef struct packed {
    logic [TW-1:0] r;
    logic [YW-1:0] y;
    logic [QW-1:0] q;
  } lane_t;

  typedef struct packed {
    side_t         side;
    logic [SW-1:0] s;
    lane_t         lx;
    lane_t         ly;
  } pkt_t;

endpackage
`default_nettype wire

>>> src/srl_front.sv
`default_nettype none
module srl_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic signed [srl_pkg::CW-1:0] sx,
  input  wire logic signed [srl_pkg::CW-1:0] sy,
  input  wire logic signed [srl_pkg::CW-1:0] ex,
  input  wire logic signed [srl_pkg::CW-1:0] ey,
  input  wire logic [srl_pkg::LW-1:0]    len,
  output logic                           vld,
  output srl_pkg::pkt_t                  pkt
);

  logic signed [srl_pkg::CW:0] dx, dy;
  logic [srl_pkg::CW-1:0] ax, ay;
  srl_pkg::side_t side_nxt;

  // stage a: differences, magnitudes and segment kind
  always_comb begin
    dx = {ex[srl_pkg::CW-1], ex} - {sx[srl_pkg::CW-1], sx};
    dy = {ey[srl_pkg::CW-1], ey} - {sy[srl_pkg::CW-1], sy};
    ax = dx[srl_pkg::CW] ? (~dx[srl_pkg::CW-1:0] + 32'd1) : dx[srl_pkg::CW-1:0];
    ay = dy[srl_pkg::CW] ? (~dy[srl_pkg::CW-1:0] + 32'd1) : dy[srl_pkg::CW-1:0];
    side_nxt.sx    = sx;
    side_nxt.sy    = sy;
    side_nxt.ex    = ex;
    side_nxt.ey    = ey;
    side_nxt.len   = len;
    side_nxt.vert  = (dx == '0);
    side_nxt.horiz = (dx != '0) && (dy == '0);
    side_nxt.xpos  = !dx[srl_pkg::CW] && (dx != '0);
    side_nxt.ypos  = !dy[srl_pkg::CW] && (dy != '0);
  end

  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r;
  srl_pkg::side_t a_side_r, b_side_r, c_side_r, d_side_r;
  logic [srl_pkg::CW-1:0] a_ax_r, a_ay_r;
  logic [62:0] b_px_r, b_py_r;
  logic [63:0] b_sqx_r, b_sqy_r;
  logic [srl_pkg::SW-1:0] c_s_r, d_s_r;
  logic [61:0] c_hhx_r, c_hhy_r;
  logic [62:0] c_hlx_r, c_hly_r;
  logic [63:0] c_llx_r, c_lly_r;
  logic [srl_pkg::TW-1:0] d_tx_r, d_ty_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  // stages a to d: products, partial squares, sums
  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= side_nxt;
      a_ax_r   <= ax;
      a_ay_r   <= ay;
      b_side_r <= a_side_r;
      b_px_r   <= a_side_r.len * a_ax_r;
      b_py_r   <= a_side_r.len * a_ay_r;
      b_sqx_r  <= a_ax_r * a_ax_r;
      b_sqy_r  <= a_ay_r * a_ay_r;
      c_side_r <= b_side_r;
      c_s_r    <= {1'b0, b_sqx_r} + {1'b0, b_sqy_r};
      c_hhx_r  <= b_px_r[62:32] * b_px_r[62:32];
      c_hlx_r  <= b_px_r[62:32] * b_px_r[31:0];
      c_llx_r  <= b_px_r[31:0] * b_px_r[31:0];
      c_hhy_r  <= b_py_r[62:32] * b_py_r[62:32];
      c_hly_r  <= b_py_r[62:32] * b_py_r[31:0];
      c_lly_r  <= b_py_r[31:0] * b_py_r[31:0];
      d_side_r <= c_side_r;
      d_s_r    <= c_s_r;
      d_tx_r   <= {c_hhx_r, 64'b0} + {30'b0, c_hlx_r, 33'b0} + {62'b0, c_llx_r};
      d_ty_r   <= {c_hhy_r, 64'b0} + {30'b0, c_hly_r, 33'b0} + {62'b0, c_lly_r};
    end
  end

  // seed the recurrence: remainder is the target square
  always_comb begin
    vld       = d_vld_r;
    pkt.side  = d_side_r;
    pkt.s     = d_s_r;
    pkt.lx.r  = d_tx_r;
    pkt.lx.y  = '0;
    pkt.lx.q  = '0;
    pkt.ly.r  = d_ty_r;
    pkt.ly.y  = '0;
    pkt.ly.q  = '0;
  end

endmodule
`default_nettype wire

>>> src/srl_cell.sv
`default_nettype none
module srl_cell #(
  parameter int K = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_in,
  input  wire srl_pkg::pkt_t pkt_in,
  output logic               vld_out,
  output srl_pkg::pkt_t      pkt_out
);

  // try bit k: keep it if (q + 2^k)^2 * S still fits under the target
  function automatic srl_pkg::lane_t step(srl_pkg::lane_t l, logic [srl_pkg::SW-1:0] s);
    logic [srl_pkg::IW-1:0] inc;
    srl_pkg::lane_t o;
    inc = (srl_pkg::IW'(l.y) << (K + 1)) + (srl_pkg::IW'(s) << (2 * K));
    o = l;
    if (inc <= srl_pkg::IW'(l.r)) begin
      o.r    = l.r - inc[srl_pkg::TW-1:0];
      o.y    = l.y + (srl_pkg::YW'(s) << K);
      o.q[K] = 1'b1;
    end
    return o;
  endfunction

  srl_pkg::pkt_t pkt_nxt;

  always_comb begin
    pkt_nxt    = pkt_in;
    pkt_nxt.lx = step(pkt_in.lx, pkt_in.s);
    pkt_nxt.ly = step(pkt_in.ly, pkt_in.s);
  end

  // hand on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pkt_out <= pkt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/segment_resize_to_length_top.sv
// pipeline: 4 product stages, 31 bit cells of the offset recurrence and
// 1 output register lie between an accepted word and out_tvalid
// throughput: one word per cycle; the whole pipe holds while out_tvalid is high and out_tready is low
// reset: synchronous active-low rst_n clears the valid bits, payload is not reset
`default_nettype none
module segment_resize_to_length_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // start_x, start_y, end_x, end_y, target_length, pad bit
  input  wire logic [159:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // new_end_x, new_end_y
  output logic [63:0]       out_tdata,
  // saturated
  output logic              out_tuser
);

  `include "segment_resize_to_length_top_macros.svh"

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic          vld_c [0:srl_pkg::QW];
  srl_pkg::pkt_t pkt_c [0:srl_pkg::QW];

  // product stages
  srl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .sx       (in_tdata[31:0]),
    .sy       (in_tdata[63:32]),
    .ex       (in_tdata[95:64]),
    .ey       (in_tdata[127:96]),
    .len      (in_tdata[158:128]),
    .vld      (vld_c[0]),
    .pkt      (pkt_c[0])
  );

  // one cell per offset bit, most significant first
  for (genvar i = 0; i < srl_pkg::QW; i++) begin : g_cell
    srl_cell #(.K(srl_pkg::QW - 1 - i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld_c[i]),
      .pkt_in  (pkt_c[i]),
      .vld_out (vld_c[i+1]),
      .pkt_out (pkt_c[i+1])
    );
  end

  // clamp to 32 bits, top bit flags saturation
  function automatic logic [32:0] clamp(logic signed [33:0] v);
    logic [32:0] o;
    if (v > 34'sh0_7FFF_FFFF) begin
      o = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -34'sh0_8000_0000) begin
      o = {1'b1, 32'h8000_0000};
    end else begin
      o = {1'b0, v[31:0]};
    end
    return o;
  endfunction

  srl_pkg::side_t sd;
  logic signed [33:0] sx_w, sy_w, offx, offy, nx, ny;
  logic [32:0] cx, cy;

  // apply offsets with the sign of each axis; an axis-aligned segment takes len directly
  always_comb begin
    sd   = pkt_c[srl_pkg::QW].side;
    sx_w = {{2{sd.sx[31]}}, sd.sx};
    sy_w = {{2{sd.sy[31]}}, sd.sy};
    if (sd.vert) begin
      offx = '0;
      offy = {3'b0, sd.len};
    end else if (sd.horiz) begin
      offx = {3'b0, sd.len};
      offy = '0;
    end else begin
      offx = {3'b0, pkt_c[srl_pkg::QW].lx.q};
      offy = {3'b0, pkt_c[srl_pkg::QW].ly.q};
    end
    nx = sd.xpos ? sx_w + offx : sx_w - offx;
    ny = sd.ypos ? sy_w + offy : sy_w - offy;
    cx = clamp(nx);
    cy = clamp(ny);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= vld_c[srl_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {cy[31:0], cx[31:0]};
      out_tuser <= cx[32] | cy[32];
    end
  end

  // checks
  `SRL_ASSERT_NOW(a_ready_rule, 1'b1, in_tready == (!out_tvalid || out_tready), "ready rule broken")
  `SRL_ASSERT_NEXT(a_hold_valid, !in_tready, out_tvalid, "stalled word lost")
  `SRL_ASSERT_NOW(a_sat_bound, out_tvalid && out_tuser, (out_tdata[31:0] == 32'h7FFF_FFFF) || (out_tdata[31:0] == 32'h8000_0000) || (out_tdata[63:32] == 32'h7FFF_FFFF) || (out_tdata[63:32] == 32'h8000_0000), "saturated word not at a bound")

endmodule
`default_nettype wire
